@@ design/arw_pkg.sv @@
`timescale 1ns / 1ps

package arw_pkg;

    localparam int SEQ_W   = 48;
    localparam int CNT_W   = 32;
    localparam int REQ_W   = 2;
    localparam int CFG_W   = 7;

    localparam logic [CFG_W-1:0] LEN_RESET = 7'd64;

    // raw request codes on the input channel
    localparam logic [REQ_W-1:0] REQ_CHECK = 2'd0;
    localparam logic [REQ_W-1:0] REQ_MARK  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        OP_CHECK = 2'd0,
        OP_MARK  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [SEQ_W-1:0] seq;
    } t_item;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

endpackage

@@ design/arw_ifs.sv @@
`timescale 1ns / 1ps

interface arw_req_if import arw_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [SEQ_W-1:0] seq_number;

    modport source (output valid, output req_type, output seq_number, input ready);
    modport sink   (input valid, input req_type, input seq_number, output ready);
endinterface

interface arw_rsp_if import arw_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             seq_acceptable;
    logic             was_duplicate;
    logic [SEQ_W-1:0] highest_seen;
    logic [CNT_W-1:0] received_total;
    logic [CNT_W-1:0] replay_total;

    modport source (
        output valid, output seq_acceptable, output was_duplicate,
        output highest_seen, output received_total, output replay_total,
        input ready
    );
    modport sink (
        input valid, input seq_acceptable, input was_duplicate,
        input highest_seen, input received_total, input replay_total,
        output ready
    );
endinterface

interface arw_cfg_if import arw_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/arw_front.sv @@
`timescale 1ns / 1ps

module arw_front import arw_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    arw_req_if.sink         i_req,
    output logic            o_q_valid,
    input  logic            i_q_ready,
    output t_item           o_q_item
);

    t_item       r_q [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_count;
    logic [1:0]  n_count;
    logic        push;
    logic        pop;
    t_item       in_item;

    function automatic t_op decode(input logic [REQ_W-1:0] code);
        t_op op;
        case (code)
            REQ_CHECK: op = OP_CHECK;
            REQ_MARK:  op = OP_MARK;
            REQ_CLEAR: op = OP_CLEAR;
            default:   op = OP_NOP;
        endcase
        return op;
    endfunction

    assign i_req.ready = (r_count != 2'd2);
    assign push        = i_req.valid && i_req.ready;
    assign pop         = o_q_valid && i_q_ready;
    assign o_q_valid   = (r_count != 2'd0);
    assign o_q_item    = r_q[r_rptr];

    assign in_item.op  = decode(i_req.req_type);
    assign in_item.seq = i_req.seq_number;

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= in_item;
        end
    end

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_count == $past(r_count) + 2'd1)
        else $error("queue count did not follow a lone push");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> r_wptr == r_rptr)
        else $error("queue pointers disagree with count");

endmodule

@@ design/arw_back.sv @@
`timescale 1ns / 1ps

module arw_back import arw_pkg::*; #(
    parameter int WINDOW_MAX = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    output logic            o_q_ready,
    input  t_item           i_q_item,
    input  logic [CFG_W-1:0] i_win_len,
    arw_rsp_if.source       o_rsp
);

    localparam int LW = ($clog2(WINDOW_MAX + 1) > CFG_W) ? $clog2(WINDOW_MAX + 1) : CFG_W;
    localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    logic [SEQ_W-1:0]      r_highest;
    logic [WINDOW_MAX-1:0] r_seen;
    logic [CNT_W-1:0]      r_rcv;
    logic [CNT_W-1:0]      r_rep;
    logic                  r_out_valid;
    logic                  r_acc;
    logic                  r_dup;

    logic [SEQ_W-1:0]      n_highest;
    logic [WINDOW_MAX-1:0] n_seen;
    logic [CNT_W-1:0]      n_rcv;
    logic [CNT_W-1:0]      n_rep;
    logic                  n_acc;
    logic                  n_dup;

    logic                  pop;
    logic [LW-1:0]         len_ext;
    logic [LW-1:0]         eff_len;
    logic [SEQ_W-1:0]      eff_len_seq;
    logic [SEQ_W-1:0]      s;
    logic [SEQ_W-1:0]      diff;
    logic [SEQ_W-1:0]      fwd_dist;
    logic                  empty;
    logic                  higher;
    logic                  in_win;
    logic                  bit_set;

    assign o_q_ready = !r_out_valid || o_rsp.ready;
    assign pop       = i_q_valid && o_q_ready;

    // zero or oversized length means the full window
    assign len_ext     = LW'(i_win_len);
    assign eff_len     = (len_ext == '0 || len_ext > LW'(WINDOW_MAX)) ? LW'(WINDOW_MAX) : len_ext;
    assign eff_len_seq = SEQ_W'(eff_len);

    assign s        = i_q_item.seq;
    assign empty    = (r_highest == '0);
    assign higher   = (s > r_highest);
    assign diff     = r_highest - s;
    assign fwd_dist = s - r_highest;
    assign in_win   = (diff < eff_len_seq);
    assign bit_set  = r_seen[diff[IW-1:0]];

    always_comb begin
        n_highest = r_highest;
        n_seen    = r_seen;
        n_rcv     = r_rcv;
        n_rep     = r_rep;
        n_acc     = 1'b0;
        n_dup     = 1'b0;
        case (i_q_item.op)
            OP_CHECK: begin
                n_acc = empty || higher || (in_win && !bit_set);
            end
            OP_MARK: begin
                if (empty) begin
                    n_highest = s;
                    n_seen[0] = 1'b1;
                    if (r_rcv != CNT_MAX) n_rcv = r_rcv + CNT_W'(1);
                end else if (higher) begin
                    if (fwd_dist >= eff_len_seq) begin
                        n_seen = '0;
                    end else begin
                        n_seen = r_seen << fwd_dist[LW-1:0];
                    end
                    n_seen[0] = 1'b1;
                    n_highest = s;
                    if (r_rcv != CNT_MAX) n_rcv = r_rcv + CNT_W'(1);
                end else if (in_win) begin
                    if (!bit_set) begin
                        n_seen[diff[IW-1:0]] = 1'b1;
                        if (r_rcv != CNT_MAX) n_rcv = r_rcv + CNT_W'(1);
                    end else begin
                        n_dup = 1'b1;
                        if (r_rep != CNT_MAX) n_rep = r_rep + CNT_W'(1);
                    end
                end
            end
            OP_CLEAR: begin
                n_highest = '0;
                n_seen    = '0;
                n_rcv     = '0;
                n_rep     = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_highest   <= '0;
            r_seen      <= '0;
            r_rcv       <= '0;
            r_rep       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_highest   <= n_highest;
                r_seen      <= n_seen;
                r_rcv       <= n_rcv;
                r_rep       <= n_rep;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_acc <= n_acc;
            r_dup <= n_dup;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.seq_acceptable = r_acc;
    assign o_rsp.was_duplicate  = r_dup;
    assign o_rsp.highest_seen   = r_highest;
    assign o_rsp.received_total = r_rcv;
    assign o_rsp.replay_total   = r_rep;

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && i_q_item.op == OP_CLEAR |=>
            r_highest == '0 && r_seen == '0 && r_rcv == '0 && r_rep == '0)
        else $error("clear left window state behind");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_acc && r_dup))
        else $error("acceptable and duplicate both set");

    a_replay_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && n_dup && r_rep != CNT_MAX |=> r_rep == $past(r_rep) + CNT_W'(1) && r_dup)
        else $error("duplicate mark not counted");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !pop |=> $stable(r_highest) && $stable(r_rcv) && $stable(r_rep))
        else $error("window state moved without a transaction");

endmodule

@@ design/anti_replay_window.sv @@
// anti-replay window: check, mark or clear one record sequence number per transaction
// result path: an accepted request waits in a queue slot, then in the result register
// throughput: 1 transaction per cycle unless results stall, set by the window update
//   (compare, barrel shift of the bitmap and counter update in the back end)
// reset: synchronous active low; empties window, counters and queue, window_length = 64
// configuration port always ready; write only while no transaction is in flight
`timescale 1ns / 1ps

module anti_replay_window import arw_pkg::*; #(
    parameter int WINDOW_MAX = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    arw_cfg_if.sink    i_cfg,
    arw_req_if.sink    i_req,
    arw_rsp_if.source  o_rsp
);

    logic [CFG_W-1:0] r_win_len;
    logic             q_valid;
    logic             q_ready;
    t_item            q_item;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len <= LEN_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_win_len <= i_cfg.data;
        end
    end

    arw_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_item  (q_item)
    );

    arw_back #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q_item  (q_item),
        .i_win_len (r_win_len),
        .o_rsp     (o_rsp)
    );

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

typedef struct {
    logic                      ok;
    logic                      dup;
    logic [arw_pkg::SEQ_W-1:0] highest;
    logic [arw_pkg::CNT_W-1:0] received;
    logic [arw_pkg::CNT_W-1:0] replays;
} t_window_verdict;

class replay_scoreboard;
    localparam int WIN_MAX = 64;

    logic [arw_pkg::SEQ_W-1:0] top_seq;
    logic [WIN_MAX-1:0]        seen_map;
    logic [arw_pkg::CNT_W-1:0] received_cnt;
    logic [arw_pkg::CNT_W-1:0] replay_cnt;
    logic [arw_pkg::CFG_W-1:0] win_len_raw;
    t_window_verdict           pending_verdicts[$];
    int                        mismatches;

    function new();
        top_seq      = '0;
        seen_map     = '0;
        received_cnt = '0;
        replay_cnt   = '0;
        win_len_raw  = arw_pkg::LEN_RESET;
        mismatches   = 0;
    endfunction

    function int tracked_len();
        if (win_len_raw == 0 || win_len_raw > WIN_MAX) begin
            return WIN_MAX;
        end
        return int'(win_len_raw);
    endfunction

    function logic [arw_pkg::CNT_W-1:0] sat_inc(input logic [arw_pkg::CNT_W-1:0] c);
        return (c == arw_pkg::CNT_MAX) ? c : c + 1'b1;
    endfunction

    // advance the window state for one accepted transaction and queue its verdict
    function void note_request(input arw_pkg::t_op op, input logic [arw_pkg::SEQ_W-1:0] s);
        t_window_verdict           v;
        logic [arw_pkg::SEQ_W-1:0] back;
        logic [arw_pkg::SEQ_W-1:0] ahead;
        int                        len;
        len   = tracked_len();
        v.ok  = 1'b0;
        v.dup = 1'b0;
        back  = top_seq - s;
        ahead = s - top_seq;
        case (op)
            arw_pkg::OP_CHECK: begin
                if (top_seq == 0 || s > top_seq) begin
                    v.ok = 1'b1;
                end else if (back >= len) begin
                    v.ok = 1'b0;
                end else begin
                    v.ok = !seen_map[back];
                end
            end
            arw_pkg::OP_MARK: begin
                if (top_seq == 0) begin
                    // empty window: older bits are left alone
                    top_seq      = s;
                    seen_map[0]  = 1'b1;
                    received_cnt = sat_inc(received_cnt);
                end else if (s > top_seq) begin
                    if (ahead >= len) begin
                        seen_map = '0;
                    end else begin
                        seen_map = seen_map << ahead;
                    end
                    top_seq      = s;
                    seen_map[0]  = 1'b1;
                    received_cnt = sat_inc(received_cnt);
                end else if (back < len) begin
                    if (!seen_map[back]) begin
                        seen_map[back] = 1'b1;
                        received_cnt   = sat_inc(received_cnt);
                    end else begin
                        v.dup      = 1'b1;
                        replay_cnt = sat_inc(replay_cnt);
                    end
                end
            end
            arw_pkg::OP_CLEAR: begin
                top_seq      = '0;
                seen_map     = '0;
                received_cnt = '0;
                replay_cnt   = '0;
            end
            default: begin
            end
        endcase
        v.highest  = top_seq;
        v.received = received_cnt;
        v.replays  = replay_cnt;
        pending_verdicts.insert(pending_verdicts.size(), v);
    endfunction

    function void check_result(input logic ok, input logic dup,
                               input logic [arw_pkg::SEQ_W-1:0] highest,
                               input logic [arw_pkg::CNT_W-1:0] received,
                               input logic [arw_pkg::CNT_W-1:0] replays);
        t_window_verdict e;
        if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected result: ok=%0d dup=%0d high=%h rcv=%0d rep=%0d",
                         ok, dup, highest, received, replays);
            end
            return;
        end
        e = pending_verdicts.pop_front();
        if (e.ok !== ok || e.dup !== dup || e.highest !== highest ||
            e.received !== received || e.replays !== replays) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: expected ok=%0d dup=%0d high=%h rcv=%0d rep=%0d",
                         e.ok, e.dup, e.highest, e.received, e.replays);
                $display("          actual   ok=%0d dup=%0d high=%h rcv=%0d rep=%0d",
                         ok, dup, highest, received, replays);
            end
        end
    endfunction
endclass

module testbench;
    import arw_pkg::*;

    localparam int PHASE_ITEMS = 228;
    localparam logic [SEQ_W-1:0] SEQ_TOP = {SEQ_W{1'b1}};

    logic i_clk;
    logic i_rst_n;

    arw_req_if req_if();
    arw_rsp_if rsp_if();
    arw_cfg_if cfg_if();

    replay_scoreboard sb;
    bit sender_gaps;
    bit sink_stalls;
    bit hold_wanted;

    anti_replay_window #(.WINDOW_MAX(64)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("testbench failed");
        $finish;
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_wanted) begin
                hold_wanted = 1'b0;
                hold_left   = 120;
            end
            if (!i_rst_n) begin
                rsp_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 13);
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                sb.check_result(rsp_if.seq_acceptable, rsp_if.was_duplicate,
                                rsp_if.highest_seen, rsp_if.received_total,
                                rsp_if.replay_total);
            end
            if (cfg_if.valid && cfg_if.ready) begin
                sb.win_len_raw = cfg_if.data;
            end
            if (req_if.valid && req_if.ready) begin
                sb.note_request(t_op'(req_if.req_type), req_if.seq_number);
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_item(input t_op op, input logic [SEQ_W-1:0] s);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.req_type   <= op;
        req_if.seq_number <= s;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    task automatic send_random_item();
        int               pick;
        t_op              op;
        logic [SEQ_W-1:0] s;
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            op = OP_CLEAR;
        end else if (pick < 4) begin
            op = OP_NOP;
        end else if (pick < 42) begin
            op = OP_CHECK;
        end else begin
            op = OP_MARK;
        end
        // mostly numbers around the window edge, some far jumps and tiny values
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            s = sb.top_seq + SEQ_W'($urandom_range(0, 80)) - SEQ_W'(72);
        end else if (pick < 80) begin
            s = sb.top_seq + SEQ_W'($urandom_range(1, 130));
        end else if (pick < 92) begin
            s = {16'($urandom), $urandom};
        end else begin
            s = SEQ_W'($urandom_range(0, 15));
        end
        send_item(op, s);
    endtask

    task automatic write_window_length(input logic [CFG_W-1:0] len);
        req_if.valid <= 1'b0;
        while (sb.pending_verdicts.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= len;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        logic [CFG_W-1:0] plan [8];
        sb = new();
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        hold_wanted = 1'b0;
        i_rst_n           <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.req_type   <= OP_CHECK;
        req_if.seq_number <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.data       <= '0;
        plan[0] = 7'd1;
        plan[1] = 7'd0;
        plan[2] = 7'd127;
        plan[3] = 7'd33;
        plan[4] = 7'd100;
        plan[5] = 7'd2;
        plan[6] = CFG_W'($urandom_range(0, 127));
        plan[7] = 7'd64;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part at the reset window length
        send_item(OP_CHECK, 48'd5);
        send_item(OP_MARK,  48'd0);
        send_item(OP_MARK,  48'd0);     // zero keeps the window empty, counts again
        send_item(OP_CHECK, 48'd0);
        send_item(OP_MARK,  48'd100);
        send_item(OP_CHECK, 48'd100);
        send_item(OP_MARK,  48'd100);
        send_item(OP_CHECK, 48'd101);
        send_item(OP_CHECK, 48'd37);    // last slot inside the window
        send_item(OP_CHECK, 48'd36);    // first slot past it
        send_item(OP_MARK,  48'd37);
        send_item(OP_MARK,  48'd37);
        send_item(OP_MARK,  48'd36);
        send_item(OP_MARK,  48'd163);   // shift by one less than the length
        send_item(OP_CHECK, 48'd100);
        send_item(OP_MARK,  48'd227);   // shift by exactly the length
        send_item(OP_NOP,   SEQ_TOP);
        send_item(OP_MARK,  SEQ_TOP);
        send_item(OP_CHECK, SEQ_TOP);
        send_item(OP_CHECK, 48'd0);
        send_item(OP_MARK,  SEQ_TOP - 1'b1);
        send_item(OP_MARK,  SEQ_TOP - 1'b1);
        send_item(OP_CLEAR, 48'h5555_5555_5555);
        send_item(OP_CHECK, SEQ_TOP);
        send_item(OP_MARK,  48'hAAAA_AAAA_AAAA);

        for (int p = 0; p < 8; p++) begin
            write_window_length(plan[p]);
            if (p == 2) begin
                hold_wanted = 1'b1;
            end
            if (p == 7) begin
                sender_gaps = 1'b0;
                sink_stalls = 1'b0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random_item();
            end
        end

        req_if.valid <= 1'b0;
        while (sb.pending_verdicts.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
design/arw_pkg.sv
design/arw_ifs.sv
design/arw_front.sv
design/arw_back.sv
design/anti_replay_window.sv
test/testbench.sv
